/* rtl/wspi_pkg.sv */
// wheel speed pi controller: shared types and constants
`timescale 1ns / 1ps
`default_nettype none
package wspi_pkg;

	localparam int DATA_W  = 32;
	localparam int TICK_W  = 16;
	localparam int INTEG_W = 48;
	// multiplicand width: a 48 bit integral or a 33 bit error sum, signed
	localparam int MC_W    = 50;
	// product accumulator: 48x32 product plus two 32x32 products, with headroom
	localparam int ACC_W   = 82;
	localparam int STEP_W  = 6;
	localparam int ADDR_W  = 4;

	localparam logic [STEP_W-1:0] STEPS_TICK = STEP_W'(TICK_W);
	localparam logic [STEP_W-1:0] STEPS_GAIN = STEP_W'(DATA_W);

	localparam logic [DATA_W-1:0] TORQUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] TORQUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_SETPOINT = 2'd0,
		REG_KP       = 2'd1,
		REG_KI       = 2'd2,
		REG_KR       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kr;
	} cfg_t;

	typedef struct packed {
		logic signed [MC_W-1:0] mcand;
		logic [DATA_W-1:0]      mplier;
		logic [STEP_W-1:0]      steps;
		logic                   mplier_signed;
		logic                   negate;
		logic                   clear;
	} mac_cmd_t;

endpackage
`default_nettype wire

/* rtl/wspi_cfg.sv */
// wheel speed pi controller: apb register file for setpoint and gains
`timescale 1ns / 1ps
`default_nettype none
module wspi_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wspi_pkg::ADDR_W-1:0] paddr,
	input  wire logic [wspi_pkg::DATA_W-1:0] pwdata,
	output logic      [wspi_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output wspi_pkg::cfg_t                   cfg
);
	import wspi_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SETPOINT: cfg_q.setpoint <= pwdata;
				REG_KP:       cfg_q.kp       <= pwdata;
				REG_KI:       cfg_q.ki       <= pwdata;
				REG_KR:       cfg_q.kr       <= pwdata;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETPOINT: prdata = cfg_q.setpoint;
			REG_KP:       prdata = cfg_q.kp;
			REG_KI:       prdata = cfg_q.ki;
			REG_KR:       prdata = cfg_q.kr;
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/wspi_mac.sv */
// wheel speed pi controller: bit-serial shift-add multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none
module wspi_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire wspi_pkg::mac_cmd_t                 cmd,
	output logic                                    busy,
	output logic signed [wspi_pkg::ACC_W-1:0]       acc
);
	import wspi_pkg::*;

	logic [ACC_W-1:0]        a_q;
	logic [DATA_W-1:0]       b_q;
	logic [STEP_W-1:0]       cnt_q;
	logic                    busy_q;
	logic                    neg_q;
	logic                    sgn_q;
	logic signed [ACC_W-1:0] acc_q;

	logic                    last;
	logic                    sub;
	logic [ACC_W-1:0]        addend;
	logic [ACC_W-1:0]        sum;

	// top multiplier bit carries negative weight when the multiplier is signed
	assign last   = (cnt_q == STEP_W'(1));
	assign sub    = neg_q ^ (last & sgn_q);
	assign addend = sub ? ~a_q : a_q;
	assign sum    = acc_q + addend + ACC_W'(sub);
	assign busy   = busy_q;
	assign acc    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= {{(ACC_W-MC_W){cmd.mcand[MC_W-1]}}, cmd.mcand};
			b_q   <= cmd.mplier;
			neg_q <= cmd.negate;
			sgn_q <= cmd.mplier_signed;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= sum;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule
`default_nettype wire

/* rtl/wheel_speed_pi_controller.sv */
// wheel speed pi controller: sequencer, controller state and stream ports
// per sample: error, tick product, integral update, then the kp, ki and kr gain products
// the input takes a new sample only in idle, as the single one-bit-per-cycle mac
// does every product; the output register frees the input side while a result waits
// to be taken
// reset: asynchronous, clears gains, setpoint, previous error and integral
`timescale 1ns / 1ps
`default_nettype none
module wheel_speed_pi_controller #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// sample stream in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,   // wheel_speed, body_rate, elapsed_ticks
	// torque stream out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // torque_cmd
	output logic [0:0]       m_axis_tuser    // torque_clipped
);
	import wspi_pkg::*;

	// one-hot sequencer: error, trapezoid product, integral update, three gain products
	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_ERR      = 11'b000_0000_0010,
		ST_TICK_GO  = 11'b000_0000_0100,
		ST_TICK_RUN = 11'b000_0000_1000,
		ST_INTEG    = 11'b000_0001_0000,
		ST_KP_RUN   = 11'b000_0010_0000,
		ST_KI_GO    = 11'b000_0100_0000,
		ST_KI_RUN   = 11'b000_1000_0000,
		ST_KR_GO    = 11'b001_0000_0000,
		ST_KR_RUN   = 11'b010_0000_0000,
		ST_EMIT     = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	cfg_t cfg;

	// captured sample
	logic signed [DATA_W-1:0] speed_q;
	logic signed [DATA_W-1:0] rate_q;
	logic [TICK_W-1:0]        ticks_q;

	// controller state
	logic signed [DATA_W-1:0]  err_q;
	logic signed [DATA_W-1:0]  prev_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic                      clip_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] torque_q;
	logic              clipped_q;

	// mac interface
	logic                    mac_start;
	mac_cmd_t                mac_cmd;
	logic                    mac_busy;
	logic signed [ACC_W-1:0] acc;

	logic in_hs;
	logic out_hs;
	logic emit_load;

	// speed error, saturated to 32 bits
	logic signed [DATA_W:0]   err_diff;
	logic signed [DATA_W-1:0] err_sat;

	// trapezoid increment and new integral
	logic signed [DATA_W:0]    err_pair;
	logic signed [MC_W-2:0]    inc;
	logic signed [MC_W-1:0]    integ_sum;
	logic                      integ_ovf;
	logic signed [INTEG_W-1:0] integ_new;

	// torque rounding and saturation
	logic signed [ACC_W-1:0]    acc_shr;
	logic [ACC_W-DATA_W:0]      acc_hi;
	logic                       torque_ovf;
	logic [DATA_W-1:0]          torque_new;

	wspi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wspi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.cmd    (mac_cmd),
		.busy   (mac_busy),
		.acc    (acc)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_hs         = s_axis_tvalid && s_axis_tready;
	assign out_hs        = m_axis_tvalid && m_axis_tready;
	assign emit_load     = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = torque_q;
	assign m_axis_tuser[0] = clipped_q;

	// error = wheel speed - setpoint, clamped to the 32 bit range
	assign err_diff = {speed_q[DATA_W-1], speed_q} - {cfg.setpoint[DATA_W-1], cfg.setpoint};
	assign err_sat  = (err_diff[DATA_W] != err_diff[DATA_W-1]) ?
		(err_diff[DATA_W] ? TORQUE_MIN : TORQUE_MAX) : err_diff[DATA_W-1:0];

	assign err_pair = {err_q[DATA_W-1], err_q} + {prev_err_q[DATA_W-1], prev_err_q};

	// halve the trapezoid product rounding toward minus infinity
	assign inc       = acc[MC_W-1:1];
	assign integ_sum = {{(MC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q} + {inc[MC_W-2], inc};
	assign integ_ovf = !((&integ_sum[MC_W-1:INTEG_W-1]) || !(|integ_sum[MC_W-1:INTEG_W-1]));
	assign integ_new = integ_ovf ?
		(integ_sum[MC_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}}) :
		integ_sum[INTEG_W-1:0];

	// drop the fraction bits, floor, then clamp to 32 bits
	assign acc_shr    = acc >>> FRAC_BITS;
	assign acc_hi     = acc_shr[ACC_W-1:DATA_W-1];
	assign torque_ovf = !((&acc_hi) || !(|acc_hi));
	assign torque_new = torque_ovf ? (acc[ACC_W-1] ? TORQUE_MIN : TORQUE_MAX) :
		acc_shr[DATA_W-1:0];

	// mac launch per sequencer step
	always_comb begin
		mac_start             = 1'b0;
		mac_cmd.mcand         = {{(MC_W-DATA_W-1){err_pair[DATA_W]}}, err_pair};
		mac_cmd.mplier        = {{(DATA_W-TICK_W){1'b0}}, ticks_q};
		mac_cmd.steps         = STEPS_TICK;
		mac_cmd.mplier_signed = 1'b0;
		mac_cmd.negate        = 1'b0;
		mac_cmd.clear         = 1'b1;
		case (state_q)
			ST_TICK_GO: begin
				mac_start = 1'b1;
			end
			ST_INTEG: begin
				// minus kp times error, starts the torque sum
				mac_start             = 1'b1;
				mac_cmd.mcand         = {{(MC_W-DATA_W){err_q[DATA_W-1]}}, err_q};
				mac_cmd.mplier        = cfg.kp;
				mac_cmd.steps         = STEPS_GAIN;
				mac_cmd.mplier_signed = 1'b1;
				mac_cmd.negate        = 1'b1;
			end
			ST_KI_GO: begin
				mac_start             = 1'b1;
				mac_cmd.mcand         = {{(MC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
				mac_cmd.mplier        = cfg.ki;
				mac_cmd.steps         = STEPS_GAIN;
				mac_cmd.mplier_signed = 1'b1;
				mac_cmd.negate        = 1'b1;
				mac_cmd.clear         = 1'b0;
			end
			ST_KR_GO: begin
				// rate feedforward adds in
				mac_start             = 1'b1;
				mac_cmd.mcand         = {{(MC_W-DATA_W){rate_q[DATA_W-1]}}, rate_q};
				mac_cmd.mplier        = cfg.kr;
				mac_cmd.steps         = STEPS_GAIN;
				mac_cmd.mplier_signed = 1'b1;
				mac_cmd.clear         = 1'b0;
			end
			default: begin
				mac_start = 1'b0;
			end
		endcase
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_err_q <= '0;
			integ_q    <= '0;
			clip_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_hs) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					clip_q  <= 1'b0;
					state_q <= ST_TICK_GO;
				end
				ST_TICK_GO: begin
					state_q <= ST_TICK_RUN;
				end
				ST_TICK_RUN: begin
					if (!mac_busy) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					integ_q    <= integ_new;
					prev_err_q <= err_q;
					clip_q     <= integ_ovf;
					state_q    <= ST_KP_RUN;
				end
				ST_KP_RUN: begin
					if (!mac_busy) begin
						state_q <= ST_KI_GO;
					end
				end
				ST_KI_GO: begin
					state_q <= ST_KI_RUN;
				end
				ST_KI_RUN: begin
					if (!mac_busy) begin
						state_q <= ST_KR_GO;
					end
				end
				ST_KR_GO: begin
					state_q <= ST_KR_RUN;
				end
				ST_KR_RUN: begin
					if (!mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample capture and error register
	always_ff @(posedge clk) begin
		if (in_hs) begin
			speed_q <= s_axis_tdata[31:0];
			rate_q  <= s_axis_tdata[63:32];
			ticks_q <= s_axis_tdata[79:64];
		end
		if (state_q == ST_ERR) begin
			err_q <= err_sat;
		end
	end

	// output register, holds a result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_hs) begin
				out_valid_q <= 1'b0;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			torque_q  <= torque_new;
			clipped_q <= clip_q || torque_ovf;
		end
	end

	// the sample port only opens with the mac at rest
	a_ready_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !mac_busy)
		else $error("input accepted while mac busy");

	// a new mac operation never overlaps a running one
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_start |-> !mac_busy)
		else $error("mac started while busy");

	// an accepted sample moves straight into the error step
	a_accept_to_err: assert property (@(posedge clk) disable iff (!arst_n)
		in_hs |=> (state_q == ST_ERR))
		else $error("sequencer did not start on accepted sample");

	// a result is loaded only after the last gain product has finished
	a_emit_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> !mac_busy)
		else $error("result loaded with mac still running");

endmodule
`default_nettype wire

/* verif/tb.sv */
// testbench for the wheel speed pi controller: stimulus, torque prediction and checking
`timescale 1ns / 1ps
module tb;
	import wspi_pkg::*;

	localparam int FRAC_BITS       = 16;
	// how long the block needs from a sample to its torque, used as a drain margin
	localparam int RESULT_LATENCY  = 122;
	// longest correct quiet stretch is the receiver hold-off plus one sample
	localparam int WATCHDOG_LIMIT  = 10000;
	localparam int HOLD_OFF_CYCLES = 2000;
	localparam int RANDOM_PHASES   = 9;
	localparam int PHASE_SAMPLES   = 148;
	localparam int REPORT_LIMIT    = 40;

	// error saturates to 32 bits, integral to 48 bits
	localparam longint ERR_MAX   = 64'sh7FFF_FFFF;
	localparam longint ERR_MIN   = -64'sh8000_0000;
	localparam longint INTEG_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint INTEG_MIN = -INTEG_MAX - 1;

	// one controller sample, last field in the lowest bits
	typedef struct packed {
		logic [15:0]        elapsed_ticks;
		logic signed [31:0] body_rate;
		logic signed [31:0] wheel_speed;
	} sample_t;

	typedef struct {
		logic [31:0] torque;
		logic        clipped;
	} torque_t;

	// predicts the torque of each accepted sample and checks what comes out
	class torque_scoreboard;
		cfg_t      gains;
		longint    last_err;
		longint    integral;
		torque_t   torque_due[$];
		int        fail_count;

		function new();
			gains      = '0;
			last_err   = 0;
			integral   = 0;
			fail_count = 0;
		endfunction

		function void set_gain(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_SETPOINT: gains.setpoint = v;
				REG_KP:       gains.kp = v;
				REG_KI:       gains.ki = v;
				REG_KR:       gains.kr = v;
				default:      ;
			endcase
		endfunction

		function void flag_mismatch(string field, logic [31:0] expv, logic [31:0] actv);
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$error("%s: expected %h, got %h", field, expv, actv);
		endfunction

		function void note_sample(sample_t s);
			longint             err;
			longint             trap;
			longint             integ_n;
			logic signed [127:0] w_err, w_integ, w_rate, w_kp, w_ki, w_kr;
			logic signed [127:0] acc, sh;
			torque_t            r;
			r.clipped = 1'b0;
			// speed error, saturated to 32 bits without flagging
			err = longint'(s.wheel_speed) - longint'(gains.setpoint);
			if (err > ERR_MAX)
				err = ERR_MAX;
			else if (err < ERR_MIN)
				err = ERR_MIN;
			// trapezoid step, halved with floor rounding
			trap = (err + last_err) * longint'(s.elapsed_ticks);
			integ_n = integral + (trap >>> 1);
			if (integ_n > INTEG_MAX) begin
				integ_n = INTEG_MAX;
				r.clipped = 1'b1;
			end else if (integ_n < INTEG_MIN) begin
				integ_n = INTEG_MIN;
				r.clipped = 1'b1;
			end
			integral = integ_n;
			last_err = err;
			// exact sum of the three products, then floor shift
			w_err   = err;
			w_integ = integ_n;
			w_rate  = s.body_rate;
			w_kp    = gains.kp;
			w_ki    = gains.ki;
			w_kr    = gains.kr;
			acc = w_rate * w_kr - w_err * w_kp - w_integ * w_ki;
			sh  = acc >>> FRAC_BITS;
			if ((&sh[127:31]) || !(|sh[127:31])) begin
				r.torque = sh[31:0];
			end else begin
				r.torque  = sh[127] ? TORQUE_MIN : TORQUE_MAX;
				r.clipped = 1'b1;
			end
			torque_due.push_back(r);
		endfunction

		function void check_torque(logic [31:0] torque, logic clipped);
			torque_t e;
			if (torque_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$error("torque transaction %h with no sample pending", torque);
				return;
			end
			e = torque_due.pop_front();
			if (e.torque !== torque)
				flag_mismatch("torque_cmd", e.torque, torque);
			if (e.clipped !== clipped)
				flag_mismatch("torque_clipped", 32'(e.clipped), 32'(clipped));
		endfunction

		function int left();
			return torque_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;     // wheel_speed, body_rate, elapsed_ticks
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // torque_cmd
	logic [0:0]  m_axis_tuser;          // torque_clipped

	torque_scoreboard sb = new();

	// idling control for the sender, receiver and main sequence; watchdog count
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int ready_hold = 0;
	int quiet = 0;

	wheel_speed_pi_controller #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// receiver: check every torque transaction, then pick the next tready
	always @(posedge clk) begin
		int r;
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_torque(m_axis_tdata, m_axis_tuser[0]);
		if (hold_req) begin
			// long hold-off so the block fills up and stalls its input
			hold_req = 1'b0;
			ready_hold = HOLD_OFF_CYCLES;
		end
		if (ready_hold > 0) begin
			ready_hold--;
			m_axis_tready <= 1'b0;
		end else if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				m_axis_tready <= 1'b1;
			end else begin
				ready_hold = (r < 94) ? $urandom_range(0, 5) : $urandom_range(20, 250);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// watchdog: any accepted transaction on any port restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("wheel_speed_pi_controller test failed");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_small(int maxbits);
		int          k;
		logic [31:0] m;
		k = $urandom_range(0, maxbits);
		m = $urandom & ((32'd1 << k) - 32'd1);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0:       return 32'h0000_0000;
			1:       return 32'h0000_0001;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain(bit tame, int maxbits);
		int r;
		r = $urandom_range(0, 9);
		if (tame && r < 8)
			return rand_small(maxbits);
		else if (r < 9)
			return $urandom;
		return pick_extreme();
	endfunction

	// mostly plausible samples near the setpoint, with some noise and extremes
	function automatic sample_t random_sample();
		sample_t s;
		int      r;
		r = $urandom_range(0, 9);
		s.wheel_speed = (r < 7) ? sb.gains.setpoint + rand_small(22)
			: (r < 9) ? $urandom : pick_extreme();
		r = $urandom_range(0, 9);
		s.body_rate = (r < 7) ? rand_small(22) : (r < 9) ? $urandom : pick_extreme();
		r = $urandom_range(0, 19);
		if (r < 15)
			s.elapsed_ticks = 16'($urandom_range(0, 300));
		else if (r < 18)
			s.elapsed_ticks = 16'($urandom);
		else
			s.elapsed_ticks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return s;
	endfunction

	function automatic int sender_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 8);
		return $urandom_range(20, 300);
	endfunction

	// offer one sample, note it when accepted, then idle for a random gap
	task automatic send_sample(sample_t s);
		int gap;
		s_axis_tdata  <= s;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(s);
		gap = sender_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send(logic [31:0] speed, logic [31:0] rate, logic [15:0] ticks);
		send_sample('{elapsed_ticks: ticks, body_rate: rate, wheel_speed: speed});
	endtask

	// apb write followed by a read-back of the same register
	task automatic set_reg(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_gain(idx, v);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v)
			sb.flag_mismatch("register read-back", v, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop offering, let every pending torque come out, then reprogram
	task automatic retune(logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
			logic [31:0] kr);
		s_axis_tvalid <= 1'b0;
		while (sb.left() != 0)
			@(posedge clk);
		set_reg(REG_SETPOINT, sp);
		set_reg(REG_KP, kp);
		set_reg(REG_KI, ki);
		set_reg(REG_KR, kr);
	endtask

	initial begin
		bit tame;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// extreme gains: error saturating high, integral overflowing upwards,
		// zero ticks and an odd positive trapezoid step
		retune(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
		send(32'h0000_0000, 32'h0000_0001, 16'h0001);

		// error saturating low, odd negative steps and the integral driven down from its ceiling
		retune(32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_0000);
		send(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
		send(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
		send(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
		send(32'h7FFF_FFFE, 32'h0000_0001, 16'h0001);
		send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);

		// tiny rate gain: floor rounding of a small negative torque
		retune(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		send(32'h0000_0000, 32'hFFFF_FFFF, 16'h0005);
		send(32'h0000_0000, 32'h0000_0001, 16'h0000);
		send(32'h0000_0000, 32'h8000_0000, 16'hFFFF);

		// most negative rate gain: torque saturating both ways
		retune(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
		send(32'h0000_0000, 32'h8000_0000, 16'h0000);
		send(32'h0000_0000, 32'h7FFF_FFFF, 16'h0000);
		send(32'hFFFF_FFFF, 32'h0000_0000, 16'h0003);

		// all gains back to zero
		retune(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send(32'h1234_5678, 32'h8765_4321, 16'h00FF);
		send(32'hFFFF_0000, 32'h0001_0000, 16'h0010);

		// random phases: mostly modest gains, every third one unrestricted
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			tame = (ph % 3) != 2;
			steady = 1'b0;
			retune(tame ? rand_small(24) : pick_gain(1'b0, 0), pick_gain(tame, 17),
				pick_gain(tame, 10), pick_gain(tame, 17));
			steady = (ph == 2) || (ph == 6);
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				if (ph == 4 && i == 10)
					hold_req = 1'b1;
				send_sample(random_sample());
			end
		end

		steady = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (sb.left() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 8) @(posedge clk);

		if (sb.fail_count == 0)
			$display("wheel_speed_pi_controller test passed");
		else
			$display("wheel_speed_pi_controller test failed");
		$finish;
	end

endmodule

/* wheel_speed_pi_controller.f */
rtl/wspi_pkg.sv
rtl/wspi_cfg.sv
rtl/wspi_mac.sv
rtl/wheel_speed_pi_controller.sv
verif/tb.sv
